/* design/pdb_pkg.sv */
// Package for the Porter-Duff pixel blender: channel width, mode codes,
// payload structs and the rounding fixed-point divide by ONE.
// No dependencies.
package pdb_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int PROD_BITS    = 2 * CHANNEL_BITS;
  localparam int LATENCY      = 5;

  localparam logic [CHANNEL_BITS-1:0] CH_ONE  = {CHANNEL_BITS{1'b1}};
  localparam logic [CHANNEL_BITS-1:0] CH_HALF = CH_ONE >> 1;

  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_OVER = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_IN   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_OUT  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ATOP = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_XOR  = 3'd4;

  localparam int ADDR_BITS = 3;
  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_OPACITY    = 1'b1;

  localparam logic [MODE_BITS-1:0]    MODE_RESET    = MODE_OVER;
  localparam logic [CHANNEL_BITS-1:0] OPACITY_RESET = CH_ONE;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PROD_BITS-1:0]    prod_t;

  typedef struct packed {
    chan_t fg_red;
    chan_t fg_green;
    chan_t fg_blue;
    chan_t fg_a;
    chan_t bg_red;
    chan_t bg_green;
    chan_t bg_blue;
    chan_t bg_a;
    logic  last_pixel;
  } pix_in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
    logic  out_last;
  } pix_out_t;

  // Round a product to nearest and divide by ONE = 2^N - 1.
  // x / (2^N - 1) == (x + (x >> N) + 1) >> N while the quotient stays below 2^N.
  function automatic chan_t round_div(input prod_t p);
    logic [PROD_BITS:0] x;
    logic [PROD_BITS:0] y;
    x = {1'b0, p} + {{(PROD_BITS-CHANNEL_BITS+1){1'b0}}, CH_HALF};
    y = x + (x >> CHANNEL_BITS) + {{PROD_BITS{1'b0}}, 1'b1};
    return y[CHANNEL_BITS +: CHANNEL_BITS];
  endfunction

endpackage

/* design/porter_duff_pixel_blend.sv */
// Porter-Duff compositor for one premultiplied RGBA pixel per clock.
// Depends on pdb_pkg (payload structs, mode codes, round_div).
//
// Usage:
//   Input channel: drive in_data and raise start for one cycle per pixel.
//   busy stays low, so a pixel is transferred at every edge where start is
//   high; one pixel may follow another in every cycle.
//   Result channel: out_valid marks out_data for exactly one cycle for each
//   transferred pixel. The receiver cannot stall, so results are never held;
//   each must be taken in its cycle.
//   Throughput is one pixel per clock through the five-stage pipeline:
//   opacity multiply, rounding plus factor select, factor multiply,
//   rounding, saturating add.
//   Configuration: APB-style port, blend_mode at byte 0 and opacity at
//   byte 4, pready always high. Write only while no pixel is in flight.
//   Reset (rst_n low, synchronous) clears every pipeline valid bit and sets
//   blend_mode to over and opacity to 1.0; pixels in flight are dropped.
module porter_duff_pixel_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pdb_pkg::pix_in_t               in_data,
  output logic                           out_valid,
  output pdb_pkg::pix_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pdb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CB = pdb_pkg::CHANNEL_BITS;

  logic [pdb_pkg::MODE_BITS-1:0] mode_r;
  pdb_pkg::chan_t                opacity_r;

  logic cfg_wr;
  logic accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pdb_pkg::MODE_RESET;
      opacity_r <= pdb_pkg::OPACITY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        pdb_pkg::REG_BLEND_MODE: mode_r    <= pwdata[pdb_pkg::MODE_BITS-1:0];
        pdb_pkg::REG_OPACITY:    opacity_r <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pdb_pkg::REG_BLEND_MODE: prdata = {{(32-pdb_pkg::MODE_BITS){1'b0}}, mode_r};
      pdb_pkg::REG_OPACITY:    prdata = {{(32-CB){1'b0}}, opacity_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- valid chain ----------------
  logic [pdb_pkg::LATENCY-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[pdb_pkg::LATENCY-2:0], accept};
    end
  end

  // ---------------- stage 1: opacity products ----------------
  pdb_pkg::prod_t s1_fgp_r [4];
  pdb_pkg::chan_t s1_bg_r  [4];
  logic           s1_last_r;

  always_ff @(posedge clk) begin
    s1_fgp_r[0] <= opacity_r * in_data.fg_red;
    s1_fgp_r[1] <= opacity_r * in_data.fg_green;
    s1_fgp_r[2] <= opacity_r * in_data.fg_blue;
    s1_fgp_r[3] <= opacity_r * in_data.fg_a;
    s1_bg_r[0]  <= in_data.bg_red;
    s1_bg_r[1]  <= in_data.bg_green;
    s1_bg_r[2]  <= in_data.bg_blue;
    s1_bg_r[3]  <= in_data.bg_a;
    s1_last_r   <= in_data.last_pixel;
  end

  // ---------------- stage 2: round, pick factors ----------------
  pdb_pkg::chan_t s2_fg_nxt [4];
  pdb_pkg::chan_t fa_f_nxt;
  pdb_pkg::chan_t fb_f_nxt;
  pdb_pkg::chan_t s2_fg_r   [4];
  pdb_pkg::chan_t s2_bg_r   [4];
  pdb_pkg::chan_t s2_fa_f_r;
  pdb_pkg::chan_t s2_fb_f_r;
  logic           s2_last_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2_fg_nxt[c] = pdb_pkg::round_div(s1_fgp_r[c]);
    end
    case (mode_r)
      pdb_pkg::MODE_OVER: begin
        fa_f_nxt = pdb_pkg::CH_ONE;
        fb_f_nxt = pdb_pkg::CH_ONE - s2_fg_nxt[3];
      end
      pdb_pkg::MODE_IN: begin
        fa_f_nxt = s1_bg_r[3];
        fb_f_nxt = '0;
      end
      pdb_pkg::MODE_OUT: begin
        fa_f_nxt = pdb_pkg::CH_ONE - s1_bg_r[3];
        fb_f_nxt = '0;
      end
      pdb_pkg::MODE_ATOP: begin
        fa_f_nxt = s1_bg_r[3];
        fb_f_nxt = pdb_pkg::CH_ONE - s2_fg_nxt[3];
      end
      pdb_pkg::MODE_XOR: begin
        fa_f_nxt = pdb_pkg::CH_ONE - s1_bg_r[3];
        fb_f_nxt = pdb_pkg::CH_ONE - s2_fg_nxt[3];
      end
      default: begin
        // unused codes blend to transparent black
        fa_f_nxt = '0;
        fb_f_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      s2_fg_r[c] <= s2_fg_nxt[c];
      s2_bg_r[c] <= s1_bg_r[c];
    end
    s2_fa_f_r <= fa_f_nxt;
    s2_fb_f_r <= fb_f_nxt;
    s2_last_r <= s1_last_r;
  end

  // ---------------- stage 3: factor products ----------------
  pdb_pkg::prod_t s3_ap_r [4];
  pdb_pkg::prod_t s3_bp_r [4];
  logic           s3_last_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      s3_ap_r[c] <= s2_fa_f_r * s2_fg_r[c];
      s3_bp_r[c] <= s2_fb_f_r * s2_bg_r[c];
    end
    s3_last_r <= s2_last_r;
  end

  // ---------------- stage 4: round both terms ----------------
  pdb_pkg::chan_t s4_a_r [4];
  pdb_pkg::chan_t s4_b_r [4];
  logic           s4_last_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      s4_a_r[c] <= pdb_pkg::round_div(s3_ap_r[c]);
      s4_b_r[c] <= pdb_pkg::round_div(s3_bp_r[c]);
    end
    s4_last_r <= s3_last_r;
  end

  // ---------------- stage 5: saturating add, output register ----------------
  logic [CB:0]    sum   [4];
  pdb_pkg::chan_t sat   [4];
  pdb_pkg::pix_out_t out_nxt;
  pdb_pkg::pix_out_t out_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = {1'b0, s4_a_r[c]} + {1'b0, s4_b_r[c]};
      sat[c] = sum[c][CB] ? pdb_pkg::CH_ONE : sum[c][CB-1:0];
    end
    out_nxt.out_red   = sat[0];
    out_nxt.out_green = sat[1];
    out_nxt.out_blue  = sat[2];
    out_nxt.out_alpha = sat[3];
    out_nxt.out_last  = s4_last_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[pdb_pkg::LATENCY-1];

endmodule

/* design/pdb_checker.sv */
// Port-level checks for porter_duff_pixel_blend, bound to the top level.
// Depends on pdb_pkg (LATENCY, payload structs).
module pdb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input pdb_pkg::pix_in_t              in_data,
  input logic                          out_valid,
  input pdb_pkg::pix_out_t             out_data
);

  // every transfer yields a result after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(pdb_pkg::LATENCY) out_valid)
    else $error("transferred pixel produced no result");

  // no result without a matching transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, pdb_pkg::LATENCY))
    else $error("result without a transferred pixel");

  a_last_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_last == $past(in_data.last_pixel, pdb_pkg::LATENCY))
    else $error("last marker mismatch");

  // both alphas zero give zero alpha in every mode
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.fg_a == '0 && in_data.bg_a == '0)
      |-> ##(pdb_pkg::LATENCY) (out_data.out_alpha == '0))
    else $error("nonzero alpha from two transparent pixels");

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* sim/tb_porter_duff_pixel_blend.sv */
// Self-checking testbench for porter_duff_pixel_blend: random premultiplied pixels in
// every blend mode and at several opacities, each result checked against a local predictor.
// Depends on pdb_pkg and the design files only.
`timescale 1ns / 1ps

module tb_porter_duff_pixel_blend;

  localparam logic [pdb_pkg::MODE_BITS-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [pdb_pkg::MODE_BITS-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [pdb_pkg::MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;
  localparam int RANDOM_PIXELS = 950;
  localparam int STALL_LIMIT   = 2000;
  localparam int BURST_START   = 300;
  localparam int BURST_LEN     = 150;

  // Predicts each composited pixel from the register copy and holds the results due.
  class blend_checker;
    pdb_pkg::pix_out_t                expected_pixels[$];
    logic [pdb_pkg::MODE_BITS-1:0]    mode;
    pdb_pkg::chan_t                   opacity;
    int                               errors;

    function new();
      mode    = pdb_pkg::MODE_RESET;
      opacity = pdb_pkg::OPACITY_RESET;
      errors  = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
      if (idx == pdb_pkg::REG_BLEND_MODE) begin
        mode = data[pdb_pkg::MODE_BITS-1:0];
      end else if (idx == pdb_pkg::REG_OPACITY) begin
        opacity = data[pdb_pkg::CHANNEL_BITS-1:0];
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Rounded product of two fractions: (a*b + (ONE-1)/2) / ONE.
    function pdb_pkg::chan_t frac_mul(pdb_pkg::chan_t a, pdb_pkg::chan_t b);
      logic [pdb_pkg::PROD_BITS:0] s;
      logic [pdb_pkg::PROD_BITS:0] q;
      s = (33'(a) * 33'(b)) + 33'(pdb_pkg::CH_HALF);
      q = s / 33'(pdb_pkg::CH_ONE);
      return q[pdb_pkg::CHANNEL_BITS-1:0];
    endfunction

    function pdb_pkg::chan_t sat_add(pdb_pkg::chan_t a, pdb_pkg::chan_t b);
      logic [pdb_pkg::CHANNEL_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[pdb_pkg::CHANNEL_BITS] ? pdb_pkg::CH_ONE : s[pdb_pkg::CHANNEL_BITS-1:0];
    endfunction

    function void note_pixel(pdb_pkg::pix_in_t p);
      pdb_pkg::chan_t    fgs[4];
      pdb_pkg::chan_t    bgs[4];
      pdb_pkg::chan_t    comp[4];
      pdb_pkg::chan_t    fa_f;
      pdb_pkg::chan_t    fb_f;
      pdb_pkg::pix_out_t e;
      fgs[0] = frac_mul(opacity, p.fg_red);
      fgs[1] = frac_mul(opacity, p.fg_green);
      fgs[2] = frac_mul(opacity, p.fg_blue);
      fgs[3] = frac_mul(opacity, p.fg_a);
      bgs[0] = p.bg_red;
      bgs[1] = p.bg_green;
      bgs[2] = p.bg_blue;
      bgs[3] = p.bg_a;
      case (mode)
        pdb_pkg::MODE_OVER: begin
          fa_f = pdb_pkg::CH_ONE;          fb_f = pdb_pkg::CH_ONE - fgs[3];
        end
        pdb_pkg::MODE_IN: begin
          fa_f = bgs[3];                   fb_f = '0;
        end
        pdb_pkg::MODE_OUT: begin
          fa_f = pdb_pkg::CH_ONE - bgs[3]; fb_f = '0;
        end
        pdb_pkg::MODE_ATOP: begin
          fa_f = bgs[3];                   fb_f = pdb_pkg::CH_ONE - fgs[3];
        end
        pdb_pkg::MODE_XOR: begin
          fa_f = pdb_pkg::CH_ONE - bgs[3]; fb_f = pdb_pkg::CH_ONE - fgs[3];
        end
        default: begin
          fa_f = '0;                       fb_f = '0;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        comp[c] = sat_add(frac_mul(fa_f, fgs[c]), frac_mul(fb_f, bgs[c]));
      end
      e.out_red   = comp[0];
      e.out_green = comp[1];
      e.out_blue  = comp[2];
      e.out_alpha = comp[3];
      e.out_last  = p.last_pixel;
      expected_pixels.push_back(e);
    endfunction

    function void compare_field(string name, pdb_pkg::chan_t want, pdb_pkg::chan_t got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pdb_pkg::pix_out_t got);
      pdb_pkg::pix_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with no pixel pending, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red",   want.out_red,   got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue",  want.out_blue,  got.out_blue);
      compare_field("out_alpha", want.out_alpha, got.out_alpha);
      compare_field("out_last",  pdb_pkg::chan_t'(want.out_last),
                    pdb_pkg::chan_t'(got.out_last));
    endfunction
  endclass

  logic                          clk     = 1'b0;
  logic                          rst_n   = 1'b0;
  logic                          start   = 1'b0;
  pdb_pkg::pix_in_t              in_data = '0;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [pdb_pkg::ADDR_BITS-1:0] paddr   = '0;
  logic [31:0]                   pwdata  = '0;
  logic                          busy;
  logic                          out_valid;
  pdb_pkg::pix_out_t             out_data;
  logic [31:0]                   prdata;
  logic                          pready;

  blend_checker sb = new();
  int           idle_cycles = 0;

  porter_duff_pixel_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Check results, record transferred pixels and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_pixel(out_data);
      end
      if (start && !busy) begin
        sb.note_pixel(in_data);
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  function automatic logic [pdb_pkg::MODE_BITS-1:0] pick_mode(int k);
    case (k)
      0:       return pdb_pkg::MODE_OVER;
      1:       return pdb_pkg::MODE_IN;
      2:       return pdb_pkg::MODE_OUT;
      3:       return pdb_pkg::MODE_ATOP;
      4:       return pdb_pkg::MODE_XOR;
      5:       return MODE_SPARE_5;
      6:       return MODE_SPARE_6;
      default: return MODE_SPARE_7;
    endcase
  endfunction

  function automatic pdb_pkg::chan_t rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return pdb_pkg::CH_ONE;
    return pdb_pkg::chan_t'($urandom_range(0, pdb_pkg::CH_ONE));
  endfunction

  function automatic pdb_pkg::chan_t opacity_choice();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return pdb_pkg::CH_ONE;
      2:       return pdb_pkg::chan_t'(1);
      3:       return pdb_pkg::CH_ONE - 1'b1;
      default: return pdb_pkg::chan_t'($urandom_range(0, pdb_pkg::CH_ONE));
    endcase
  endfunction

  // Mostly well-formed premultiplied pixels (color not above alpha), some raw noise.
  function automatic pdb_pkg::pix_in_t gen_pixel();
    pdb_pkg::pix_in_t p;
    if ($urandom_range(0, 99) < 75) begin
      p.fg_a     = rand_chan();
      p.fg_red   = pdb_pkg::chan_t'($urandom_range(0, p.fg_a));
      p.fg_green = pdb_pkg::chan_t'($urandom_range(0, p.fg_a));
      p.fg_blue  = pdb_pkg::chan_t'($urandom_range(0, p.fg_a));
      p.bg_a     = rand_chan();
      p.bg_red   = pdb_pkg::chan_t'($urandom_range(0, p.bg_a));
      p.bg_green = pdb_pkg::chan_t'($urandom_range(0, p.bg_a));
      p.bg_blue  = pdb_pkg::chan_t'($urandom_range(0, p.bg_a));
    end else begin
      p.fg_red   = rand_chan();
      p.fg_green = rand_chan();
      p.fg_blue  = rand_chan();
      p.fg_a     = rand_chan();
      p.bg_red   = rand_chan();
      p.bg_green = rand_chan();
      p.bg_blue  = rand_chan();
      p.bg_a     = rand_chan();
    end
    p.last_pixel = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  task automatic send_pixel(input pdb_pkg::pix_in_t p);
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // Return to idle after the access so a following write starts cleanly.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pdb_pkg::ADDR_BITS'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Junk in the unused upper data bits must be ignored.
  task automatic write_config(input logic [pdb_pkg::MODE_BITS-1:0] mode,
                              input pdb_pkg::chan_t opac);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    write_reg(pdb_pkg::REG_BLEND_MODE, {junk[31:pdb_pkg::MODE_BITS], mode});
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    write_reg(pdb_pkg::REG_OPACITY, {junk[31:pdb_pkg::CHANNEL_BITS], opac});
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (pdb_pkg::LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    pdb_pkg::pix_in_t p;
    pdb_pkg::chan_t   dir_opac;
    int               sent;
    int               phase_len;
    logic             burst;
    logic             burst_done;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corner pixels in every mode code; the first group runs on reset values.
    for (int k = 0; k < 8; k++) begin
      if (k != 0) begin
        case (k)
          1:       dir_opac = '0;
          2:       dir_opac = pdb_pkg::chan_t'(1);
          3:       dir_opac = 16'h8000;
          4:       dir_opac = pdb_pkg::CH_ONE - 1'b1;
          6:       dir_opac = 16'd12345;
          default: dir_opac = pdb_pkg::CH_ONE;
        endcase
        write_config(pick_mode(k), dir_opac);
      end
      p = '1;
      send_pixel(p);
      p = gen_pixel();
      p.fg_red   = '0;
      p.fg_green = '0;
      p.fg_blue  = '0;
      p.fg_a     = '0;
      p.bg_a     = pdb_pkg::CH_ONE;
      p.last_pixel = 1'b0;
      send_pixel(p);
      // Color above alpha on both sides, transparent background.
      p.fg_red   = pdb_pkg::CH_ONE;
      p.fg_green = pdb_pkg::CH_ONE;
      p.fg_blue  = pdb_pkg::CH_ONE;
      p.fg_a     = pdb_pkg::chan_t'($urandom_range(0, 16'h7fff));
      p.bg_red   = pdb_pkg::CH_ONE;
      p.bg_green = pdb_pkg::CH_ONE;
      p.bg_blue  = pdb_pkg::CH_ONE;
      p.bg_a     = '0;
      p.last_pixel = 1'($urandom_range(0, 1));
      send_pixel(p);
      wait_drain();
    end

    // Random phases, each under its own register setting.
    sent = 0;
    burst_done = 1'b0;
    while (sent < RANDOM_PIXELS) begin
      write_config(($urandom_range(0, 99) < 85) ? pick_mode($urandom_range(0, 4))
                                                : pick_mode($urandom_range(5, 7)),
                   opacity_choice());
      // One phase runs back to back with no gaps at all.
      burst = !burst_done && (sent >= BURST_START);
      if (burst) begin
        burst_done = 1'b1;
        phase_len  = BURST_LEN;
      end else begin
        phase_len = $urandom_range(20, 150);
      end
      for (int i = 0; i < phase_len && sent < RANDOM_PIXELS; i++) begin
        send_pixel(gen_pixel());
        sent++;
        if (!burst && $urandom_range(0, 99) < 15) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
      end
      wait_drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
